// ----- rtl/qmad_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// qmad_pkg
// Shared constants and types of the four-channel moving average and distance
// map block.
// ----------------------------------------------------------------------------
package qmad_pkg;

    localparam int CHANNELS          = 4;
    localparam int OUT_W             = 10;
    localparam int DEF_WINDOW_LENGTH = 64;
    localparam int DEF_SAMPLE_BITS   = 10;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam int          MAP_SCALE_BITS = 6;
    localparam logic [31:0] MAP_LOW_EDGE   = 32'h0000_2222;
    localparam logic [31:0] MAP_HIGH_EDGE  = 32'h0000_FFC0;
    localparam logic [OUT_W-1:0] MAP_NEAR   = OUT_W'(800);
    localparam logic [OUT_W-1:0] MAP_FAR    = OUT_W'(70);
    localparam logic [OUT_W-1:0] MAP_OFFSET = OUT_W'(913);
    localparam int MAP_SLOPE_NUM = 730;
    localparam int MAP_SLOPE_DEN = 56734;

    // On the sloped segment the scaled average stays below the upper edge.
    localparam int MAP_S_W       = 16;
    localparam int MAP_T_W       = 26;
    localparam int MAP_DIV_SHIFT = MAP_T_W + $clog2(MAP_SLOPE_DEN);
    localparam int MAP_M_W       = MAP_T_W + 2;
    localparam int MAP_DIV_W     = MAP_T_W + MAP_M_W;
    localparam logic [63:0] MAP_DIV_MULT =
        ((64'd1 << MAP_DIV_SHIFT) + 64'(MAP_SLOPE_DEN) - 64'd1) / 64'(MAP_SLOPE_DEN);

    typedef enum logic [1:0] {
        CLS_NEAR,
        CLS_FAR,
        CLS_SLOPE
    } t_map_class;

    typedef struct packed {
        logic                empty;
        logic [QUEUE_AW:0]   level;
    } t_queue_status;

endpackage
`default_nettype wire

// ----- rtl/qmad_in_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// qmad_in_if
// Sample set channel: one sample for each of the four channels per transfer.
// ----------------------------------------------------------------------------
interface qmad_in_if #(
    parameter int SAMPLE_BITS = qmad_pkg::DEF_SAMPLE_BITS
) ();
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample_ch0;
    logic [SAMPLE_BITS-1:0] sample_ch1;
    logic [SAMPLE_BITS-1:0] sample_ch2;
    logic [SAMPLE_BITS-1:0] sample_ch3;

    modport source (
        output valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
        input  ready
    );
    modport sink (
        input  valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
        output ready
    );
endinterface
`default_nettype wire

// ----- rtl/qmad_out_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// qmad_out_if
// Result channel: four window averages and four distances per transfer.
// ----------------------------------------------------------------------------
interface qmad_out_if ();
    logic                       valid;
    logic                       ready;
    logic [qmad_pkg::OUT_W-1:0] average_ch0;
    logic [qmad_pkg::OUT_W-1:0] average_ch1;
    logic [qmad_pkg::OUT_W-1:0] average_ch2;
    logic [qmad_pkg::OUT_W-1:0] average_ch3;
    logic [qmad_pkg::OUT_W-1:0] distance_ch0;
    logic [qmad_pkg::OUT_W-1:0] distance_ch1;
    logic [qmad_pkg::OUT_W-1:0] distance_ch2;
    logic [qmad_pkg::OUT_W-1:0] distance_ch3;

    modport source (
        output valid, average_ch0, average_ch1, average_ch2, average_ch3,
               distance_ch0, distance_ch1, distance_ch2, distance_ch3,
        input  ready
    );
    modport sink (
        input  valid, average_ch0, average_ch1, average_ch2, average_ch3,
               distance_ch0, distance_ch1, distance_ch2, distance_ch3,
        output ready
    );
endinterface
`default_nettype wire

// ----- rtl/qmad_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// qmad_front
// Accepts sample sets, keeps the history rings and the running window sums,
// and pushes the updated sums into the queue.
// ----------------------------------------------------------------------------
module qmad_front #(
    parameter int WINDOW_LENGTH = qmad_pkg::DEF_WINDOW_LENGTH,
    parameter int SAMPLE_BITS   = qmad_pkg::DEF_SAMPLE_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    qmad_in_if.sink                 i_samples,
    input  qmad_pkg::t_queue_status i_queue_status,
    output logic                    o_push,
    output logic [qmad_pkg::CHANNELS-1:0][SAMPLE_BITS+$clog2(WINDOW_LENGTH)-1:0] o_sums
);

    localparam int POS_W   = $clog2(WINDOW_LENGTH);
    localparam int SUM_W   = SAMPLE_BITS + POS_W;
    localparam int LEVEL_W = qmad_pkg::QUEUE_AW + 2;

    logic [qmad_pkg::CHANNELS-1:0][SAMPLE_BITS-1:0] samples;
    logic [LEVEL_W-1:0]                             occupancy;
    logic                                           accept;

    logic [POS_W-1:0] r_pos;
    logic             r_filled;
    logic             r_f1_valid;
    logic             r_old_valid;

    logic [qmad_pkg::CHANNELS-1:0][SAMPLE_BITS-1:0] r_old;
    logic [qmad_pkg::CHANNELS-1:0][SAMPLE_BITS-1:0] r_new;
    logic [qmad_pkg::CHANNELS-1:0][SUM_W-1:0]       r_sum;
    logic [qmad_pkg::CHANNELS-1:0][SUM_W-1:0]       n_sum;

    assign samples[0] = i_samples.sample_ch0;
    assign samples[1] = i_samples.sample_ch1;
    assign samples[2] = i_samples.sample_ch2;
    assign samples[3] = i_samples.sample_ch3;

    // Every item in this stage or the queue must find a queue slot.
    assign occupancy       = LEVEL_W'(i_queue_status.level) + LEVEL_W'(r_f1_valid);
    assign i_samples.ready = occupancy < LEVEL_W'(qmad_pkg::QUEUE_DEPTH);
    assign accept          = i_samples.valid && i_samples.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_filled   <= 1'b0;
            r_f1_valid <= 1'b0;
        end else begin
            r_f1_valid <= accept;
            if (accept) begin
                if (r_pos == POS_W'(WINDOW_LENGTH - 1)) begin
                    r_pos    <= '0;
                    r_filled <= 1'b1;
                end else begin
                    r_pos <= r_pos + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_old_valid <= r_filled;
        end
    end

    for (genvar c = 0; c < qmad_pkg::CHANNELS; c++) begin : g_ring
        logic [SAMPLE_BITS-1:0] r_ring [WINDOW_LENGTH];

        always_ff @(posedge i_clk) begin
            if (accept) begin
                r_ring[r_pos] <= samples[c];
                r_old[c]      <= r_ring[r_pos];
                r_new[c]      <= samples[c];
            end
        end
    end

    // Ring entries are taken as zero until the position has wrapped once.
    always_comb begin
        for (int c = 0; c < qmad_pkg::CHANNELS; c++) begin
            n_sum[c] = r_sum[c] - (r_old_valid ? SUM_W'(r_old[c]) : SUM_W'(0))
                       + SUM_W'(r_new[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (r_f1_valid) begin
            r_sum <= n_sum;
        end
    end

    assign o_push = r_f1_valid;
    assign o_sums = n_sum;

endmodule
`default_nettype wire

// ----- rtl/qmad_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// qmad_queue
// Short first-in first-out queue of window sums between front and back.
// ----------------------------------------------------------------------------
module qmad_queue #(
    parameter int DATA_W = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  logic [DATA_W-1:0]       i_data,
    input  logic                    i_pop,
    output logic [DATA_W-1:0]       o_data,
    output qmad_pkg::t_queue_status o_status
);

    localparam int AW = qmad_pkg::QUEUE_AW;

    logic [DATA_W-1:0] r_slot [qmad_pkg::QUEUE_DEPTH];
    logic [AW-1:0]     r_wr_ptr;
    logic [AW-1:0]     r_rd_ptr;
    logic [AW:0]       r_level;
    logic [AW:0]       n_level;

    always_comb begin
        case ({i_push, i_pop})
            2'b10:   n_level = r_level + 1'b1;
            2'b01:   n_level = r_level - 1'b1;
            default: n_level = r_level;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_level <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    assign o_data         = r_slot[r_rd_ptr];
    assign o_status.empty = (r_level == '0);
    assign o_status.level = r_level;

endmodule
`default_nettype wire

// ----- rtl/qmad_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// qmad_back
// Turns window sums into averages and mapped distances in a four-stage
// pipeline that ends in the output register.
// ----------------------------------------------------------------------------
module qmad_back #(
    parameter int WINDOW_LENGTH = qmad_pkg::DEF_WINDOW_LENGTH,
    parameter int SAMPLE_BITS   = qmad_pkg::DEF_SAMPLE_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  qmad_pkg::t_queue_status i_queue_status,
    input  logic [qmad_pkg::CHANNELS-1:0][SAMPLE_BITS+$clog2(WINDOW_LENGTH)-1:0] i_sums,
    output logic                    o_pop,
    qmad_out_if.source              o_results
);

    localparam int CH        = qmad_pkg::CHANNELS;
    localparam int OUT_W     = qmad_pkg::OUT_W;
    localparam int STAGES    = 4;
    localparam int POS_W     = $clog2(WINDOW_LENGTH);
    localparam int SUM_W     = SAMPLE_BITS + POS_W;
    localparam int AVG_K     = SUM_W + POS_W;
    localparam int AVG_M_W   = SUM_W + 2;
    localparam int AVG_PROD_W = SUM_W + AVG_M_W;
    localparam logic [63:0] AVG_MULT =
        ((64'd1 << AVG_K) + 64'(WINDOW_LENGTH) - 64'd1) / 64'(WINDOW_LENGTH);

    logic [STAGES-1:0] r_valid;
    logic [STAGES-1:0] en;

    logic [CH-1:0][AVG_PROD_W-1:0]         avg_prod;
    logic [CH-1:0][31:0]                   scaled;
    logic [CH-1:0][qmad_pkg::MAP_T_W-1:0]  slope_prod;
    logic [CH-1:0][qmad_pkg::MAP_DIV_W-1:0] div_prod;
    qmad_pkg::t_map_class [CH-1:0]         cls;
    logic [CH-1:0][OUT_W-1:0]              mapped;

    logic [CH-1:0][SAMPLE_BITS-1:0]        r_avg0;
    logic [CH-1:0][SAMPLE_BITS-1:0]        r_avg1;
    logic [CH-1:0][SAMPLE_BITS-1:0]        r_avg2;
    qmad_pkg::t_map_class [CH-1:0]         r_cls1;
    qmad_pkg::t_map_class [CH-1:0]         r_cls2;
    logic [CH-1:0][qmad_pkg::MAP_T_W-1:0]  r_t1;
    logic [CH-1:0][OUT_W-1:0]              r_q2;
    logic [CH-1:0][OUT_W-1:0]              r_average;
    logic [CH-1:0][OUT_W-1:0]              r_distance;

    always_comb begin
        en[STAGES-1] = !r_valid[STAGES-1] || o_results.ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            en[k] = !r_valid[k] || en[k+1];
        end
    end

    assign o_pop = !i_queue_status.empty && en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (en[0]) begin
                r_valid[0] <= o_pop;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (en[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    always_comb begin
        for (int c = 0; c < CH; c++) begin
            avg_prod[c] = AVG_PROD_W'(i_sums[c]) * AVG_PROD_W'(AVG_MULT);
            scaled[c]   = 32'(r_avg0[c]) << qmad_pkg::MAP_SCALE_BITS;
            if (scaled[c] <= qmad_pkg::MAP_LOW_EDGE) begin
                cls[c] = qmad_pkg::CLS_NEAR;
            end else if (scaled[c] >= qmad_pkg::MAP_HIGH_EDGE) begin
                cls[c] = qmad_pkg::CLS_FAR;
            end else begin
                cls[c] = qmad_pkg::CLS_SLOPE;
            end
            slope_prod[c] = qmad_pkg::MAP_T_W'(scaled[c][qmad_pkg::MAP_S_W-1:0])
                            * qmad_pkg::MAP_T_W'(qmad_pkg::MAP_SLOPE_NUM);
            div_prod[c]   = qmad_pkg::MAP_DIV_W'(r_t1[c])
                            * qmad_pkg::MAP_DIV_W'(qmad_pkg::MAP_DIV_MULT);
            case (r_cls2[c])
                qmad_pkg::CLS_NEAR:  mapped[c] = qmad_pkg::MAP_NEAR;
                qmad_pkg::CLS_FAR:   mapped[c] = qmad_pkg::MAP_FAR;
                qmad_pkg::CLS_SLOPE: mapped[c] = qmad_pkg::MAP_OFFSET - r_q2[c];
                default:             mapped[c] = qmad_pkg::MAP_OFFSET - r_q2[c];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < CH; c++) begin
            if (en[0]) begin
                r_avg0[c] <= avg_prod[c][AVG_K +: SAMPLE_BITS];
            end
            if (en[1]) begin
                r_avg1[c] <= r_avg0[c];
                r_cls1[c] <= cls[c];
                r_t1[c]   <= slope_prod[c];
            end
            if (en[2]) begin
                r_avg2[c] <= r_avg1[c];
                r_cls2[c] <= r_cls1[c];
                r_q2[c]   <= div_prod[c][qmad_pkg::MAP_DIV_SHIFT +: OUT_W];
            end
            if (en[3]) begin
                r_average[c]  <= OUT_W'(r_avg2[c]);
                r_distance[c] <= mapped[c];
            end
        end
    end

    assign o_results.valid        = r_valid[STAGES-1];
    assign o_results.average_ch0  = r_average[0];
    assign o_results.average_ch1  = r_average[1];
    assign o_results.average_ch2  = r_average[2];
    assign o_results.average_ch3  = r_average[3];
    assign o_results.distance_ch0 = r_distance[0];
    assign o_results.distance_ch1 = r_distance[1];
    assign o_results.distance_ch2 = r_distance[2];
    assign o_results.distance_ch3 = r_distance[3];

endmodule
`default_nettype wire

// ----- rtl/quad_moving_average_distance.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// quad_moving_average_distance
// Four-channel moving average over a window of samples, with a clamped linear
// map of each average to a distance.
// ----------------------------------------------------------------------------
// One sample set is taken per clock cycle while the queue has room, and every
// set gives one result transfer. The rate is set by the history rings, each of
// which does one read and one write per cycle. A taken set passes the front
// register, the short queue and the four-stage output pipeline; the queue lets
// the input keep flowing while the result side stalls, until it fills up.
// Averages are window sums divided by the window length and floored; until
// the first window has been filled the missing samples count as zero, which a
// fill flag provides, so there is no clearing pass after reset.
module quad_moving_average_distance #(
    parameter int WINDOW_LENGTH = qmad_pkg::DEF_WINDOW_LENGTH,
    parameter int SAMPLE_BITS   = qmad_pkg::DEF_SAMPLE_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    qmad_in_if.sink    i_samples,
    qmad_out_if.source o_results
);

    localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW_LENGTH);
    localparam int DATA_W = qmad_pkg::CHANNELS * SUM_W;

    logic                                 push;
    logic                                 pop;
    logic [qmad_pkg::CHANNELS-1:0][SUM_W-1:0] push_sums;
    logic [qmad_pkg::CHANNELS-1:0][SUM_W-1:0] pop_sums;
    qmad_pkg::t_queue_status              queue_status;

    qmad_front #(
        .WINDOW_LENGTH (WINDOW_LENGTH),
        .SAMPLE_BITS   (SAMPLE_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_samples      (i_samples),
        .i_queue_status (queue_status),
        .o_push         (push),
        .o_sums         (push_sums)
    );

    qmad_queue #(
        .DATA_W (DATA_W)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (push_sums),
        .i_pop    (pop),
        .o_data   (pop_sums),
        .o_status (queue_status)
    );

    qmad_back #(
        .WINDOW_LENGTH (WINDOW_LENGTH),
        .SAMPLE_BITS   (SAMPLE_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_queue_status (queue_status),
        .i_sums         (pop_sums),
        .o_pop          (pop),
        .o_results      (o_results)
    );

endmodule
`default_nettype wire

// ----- rtl/qmad_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// qmad_checker
// Port-level checks of the moving average block, bound to its top level.
// ----------------------------------------------------------------------------
module qmad_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_ready,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic [4*qmad_pkg::OUT_W-1:0]   i_averages,
    input logic [4*qmad_pkg::OUT_W-1:0]   i_distances
);

    localparam int OUT_W = qmad_pkg::OUT_W;

    // A stalled result transfer keeps its valid and its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid
            && $stable(i_averages) && $stable(i_distances))
        else $error("result changed while stalled");

    // Reset empties the pipeline and leaves the input side open.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("block not empty after reset");

    // The distance map never leaves its clamped range.
    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |->
            i_distances[0*OUT_W +: OUT_W] >= OUT_W'(70)
            && i_distances[0*OUT_W +: OUT_W] <= OUT_W'(801)
            && i_distances[1*OUT_W +: OUT_W] >= OUT_W'(70)
            && i_distances[1*OUT_W +: OUT_W] <= OUT_W'(801)
            && i_distances[2*OUT_W +: OUT_W] >= OUT_W'(70)
            && i_distances[2*OUT_W +: OUT_W] <= OUT_W'(801)
            && i_distances[3*OUT_W +: OUT_W] >= OUT_W'(70)
            && i_distances[3*OUT_W +: OUT_W] <= OUT_W'(801))
        else $error("distance out of range");

    // With results flowing out freely the queue never closes the input side.
    a_no_throttle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready && $past(i_out_ready) && $past(i_out_ready, 2)
            && $past(i_rst_n) && $past(i_rst_n, 2) |-> i_in_ready)
        else $error("input throttled without back-pressure");

endmodule

bind quad_moving_average_distance qmad_checker u_qmad_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_samples.ready),
    .i_out_valid (o_results.valid),
    .i_out_ready (o_results.ready),
    .i_averages  ({o_results.average_ch3, o_results.average_ch2,
                   o_results.average_ch1, o_results.average_ch0}),
    .i_distances ({o_results.distance_ch3, o_results.distance_ch2,
                   o_results.distance_ch1, o_results.distance_ch0})
);
`default_nettype wire

// ----- dv/tb_quad_moving_average_distance.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quad_moving_average_distance
// Self-checking bench for the four-channel moving average and distance map.
// A short table of directed sample sets is followed by long runs of held
// signal levels, with and without noise, and by stretches of pure noise.
// Every accepted sample set is passed through a local window model, and each
// result transfer is compared field by field with the oldest expected result.
// ----------------------------------------------------------------------------
module tb_quad_moving_average_distance;

    localparam int CHANNELS     = qmad_pkg::CHANNELS;
    localparam int SAMPLE_W     = qmad_pkg::DEF_SAMPLE_BITS;
    localparam int RESULT_W     = qmad_pkg::OUT_W;
    localparam int WINDOW_LEN   = qmad_pkg::DEF_WINDOW_LENGTH;
    localparam int SLOT_W       = $clog2(WINDOW_LEN);
    localparam int SAMPLE_MAX   = (1 << SAMPLE_W) - 1;

    localparam int unsigned NEAR_EDGE   = 32'h2222;
    localparam int unsigned FAR_EDGE    = 32'hFFC0;
    localparam int unsigned NEAR_DIST   = 800;
    localparam int unsigned FAR_DIST    = 70;
    localparam int unsigned DIST_OFFSET = 913;
    localparam int unsigned SLOPE_NUM   = 730;
    localparam int unsigned SLOPE_DEN   = 56734;

    localparam int DIRECTED_ROWS = 20;
    localparam int RANDOM_SETS   = 2000;
    localparam int IDLE_PERCENT  = 38;
    localparam int QUIET_FIRST   = 400;
    localparam int QUIET_LAST    = 700;
    localparam int STALL_AFTER   = 900;
    localparam int STALL_CYCLES  = 300;
    localparam int DRAIN_CYCLES  = 20;
    localparam int CYCLE_LIMIT   = 200000;

    typedef logic [CHANNELS-1:0][SAMPLE_W-1:0] t_sample_set;

    typedef struct packed {
        logic [CHANNELS-1:0][RESULT_W-1:0] average;
        logic [CHANNELS-1:0][RESULT_W-1:0] distance;
    } t_window_result;

    typedef struct packed {
        t_sample_set    samples;
        logic           typed;
        t_window_result result;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    qmad_in_if #(.SAMPLE_BITS(SAMPLE_W)) sample_bus ();
    qmad_out_if                          result_bus ();

    quad_moving_average_distance #(
        .WINDOW_LENGTH(WINDOW_LEN),
        .SAMPLE_BITS  (SAMPLE_W)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_samples(sample_bus.sink),
        .o_results(result_bus.source)
    );

    logic [SAMPLE_W-1:0] history [CHANNELS][WINDOW_LEN];
    logic [15:0]         window_total [CHANNELS];
    logic [SLOT_W-1:0]   write_slot;

    t_window_result pending_results [$];
    t_stim_row      directed_rows [DIRECTED_ROWS];

    int sets_sent;
    int results_seen;
    int mismatches;
    int cycle_count;
    int near_hits;
    int far_hits;
    int slope_hits;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles with %0d results outstanding.",
                     cycle_count, pending_results.size());
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [RESULT_W-1:0] map_distance(input logic [RESULT_W-1:0] avg);
        int unsigned scaled;
        scaled = 32'(avg) << 6;
        if (scaled <= NEAR_EDGE) begin
            near_hits++;
            return RESULT_W'(NEAR_DIST);
        end
        if (scaled >= FAR_EDGE) begin
            far_hits++;
            return RESULT_W'(FAR_DIST);
        end
        slope_hits++;
        return RESULT_W'(DIST_OFFSET - (scaled * SLOPE_NUM) / SLOPE_DEN);
    endfunction

    function automatic t_window_result advance_window(input t_sample_set s);
        t_window_result r;
        for (int c = 0; c < CHANNELS; c++) begin
            window_total[c] = window_total[c] - 16'(history[c][write_slot]) + 16'(s[c]);
            history[c][write_slot] = s[c];
        end
        write_slot = SLOT_W'((int'(write_slot) + 1) % WINDOW_LEN);
        for (int c = 0; c < CHANNELS; c++) begin
            r.average[c]  = RESULT_W'(window_total[c] / WINDOW_LEN);
            r.distance[c] = map_distance(r.average[c]);
        end
        return r;
    endfunction

    function automatic t_window_result flat_result(input int unsigned avg,
                                                   input int unsigned distance);
        t_window_result r;
        for (int c = 0; c < CHANNELS; c++) begin
            r.average[c]  = RESULT_W'(avg);
            r.distance[c] = RESULT_W'(distance);
        end
        return r;
    endfunction

    task automatic offer_set(input t_sample_set s, input logic typed,
                             input t_window_result typed_result);
        t_window_result predicted;
        while (!(sets_sent >= QUIET_FIRST && sets_sent < QUIET_LAST) &&
               $urandom_range(99) < IDLE_PERCENT) begin
            sample_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        sample_bus.valid      <= 1'b1;
        sample_bus.sample_ch0 <= s[0];
        sample_bus.sample_ch1 <= s[1];
        sample_bus.sample_ch2 <= s[2];
        sample_bus.sample_ch3 <= s[3];
        @(posedge i_clk);
        while (sample_bus.ready !== 1'b1) @(posedge i_clk);
        predicted = advance_window(s);
        pending_results.push_back(typed ? typed_result : predicted);
        sets_sent++;
    endtask

    initial begin
        int hold_left;
        logic stall_done;
        t_window_result actual;
        t_window_result wanted;
        hold_left  = 0;
        stall_done = 1'b0;
        result_bus.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
                actual.average  = {result_bus.average_ch3, result_bus.average_ch2,
                                   result_bus.average_ch1, result_bus.average_ch0};
                actual.distance = {result_bus.distance_ch3, result_bus.distance_ch2,
                                   result_bus.distance_ch1, result_bus.distance_ch0};
                if (pending_results.size() == 0) begin
                    $error("Result transfer arrived with no sample set outstanding.");
                    mismatches++;
                end else begin
                    wanted = pending_results.pop_front();
                    for (int c = 0; c < CHANNELS; c++) begin
                        if (actual.average[c] !== wanted.average[c]) begin
                            $error("average_ch%0d: expected %0d, got %0d",
                                   c, wanted.average[c], actual.average[c]);
                            mismatches++;
                        end
                        if (actual.distance[c] !== wanted.distance[c]) begin
                            $error("distance_ch%0d: expected %0d, got %0d",
                                   c, wanted.distance[c], actual.distance[c]);
                            mismatches++;
                        end
                    end
                end
                results_seen++;
            end
            if (!stall_done && results_seen >= STALL_AFTER) begin
                stall_done = 1'b1;
                hold_left  = STALL_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_bus.ready <= 1'b0;
            end else if (results_seen >= QUIET_FIRST && results_seen < QUIET_LAST) begin
                result_bus.ready <= 1'b1;
            end else begin
                result_bus.ready <= ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    initial begin
        t_sample_set s;
        int random_sets;
        int seg_len;
        int v;
        logic noisy;
        logic first_segment;
        int level [CHANNELS];
        int spread [CHANNELS];

        i_rst_n               <= 1'b0;
        sample_bus.valid      <= 1'b0;
        sample_bus.sample_ch0 <= '0;
        sample_bus.sample_ch1 <= '0;
        sample_bus.sample_ch2 <= '0;
        sample_bus.sample_ch3 <= '0;
        cycle_count  = 0;
        sets_sent    = 0;
        results_seen = 0;
        mismatches   = 0;
        near_hits    = 0;
        far_hits     = 0;
        slope_hits   = 0;
        write_slot   = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            window_total[c] = '0;
            for (int k = 0; k < WINDOW_LEN; k++) history[c][k] = '0;
        end

        // A single full-scale set after an all-zero one lifts the average by
        // a sixty-fourth of full scale, which is still on the near clamp.
        directed_rows[0] = '{samples: '0, typed: 1'b1, result: flat_result(0, NEAR_DIST)};
        directed_rows[1] = '{samples: {CHANNELS{SAMPLE_W'(SAMPLE_MAX)}}, typed: 1'b1,
                             result: flat_result(15, NEAR_DIST)};
        directed_rows[2] = '{samples: {10'h000, 10'h3FF, 10'h2AA, 10'h155},
                             typed: 1'b0, result: '0};
        directed_rows[3] = '{samples: {10'h3FF, 10'h000, 10'h155, 10'h2AA},
                             typed: 1'b0, result: '0};
        for (int k = 0; k < 10; k++) begin
            for (int c = 0; c < CHANNELS; c++) s[c] = SAMPLE_W'(1 << ((k + c) % SAMPLE_W));
            directed_rows[4 + k] = '{samples: s, typed: 1'b0, result: '0};
        end
        for (int k = 14; k < DIRECTED_ROWS; k++) begin
            directed_rows[k] = '{samples: {CHANNELS{SAMPLE_W'(SAMPLE_MAX)}},
                                 typed: 1'b0, result: '0};
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < DIRECTED_ROWS; k++) begin
            offer_set(directed_rows[k].samples, directed_rows[k].typed,
                      directed_rows[k].result);
        end

        random_sets   = 0;
        first_segment = 1'b1;
        while (random_sets < RANDOM_SETS) begin
            seg_len = first_segment ? 80 : $urandom_range(160, 64);
            noisy   = !first_segment && ($urandom_range(4) == 0);
            for (int c = 0; c < CHANNELS; c++) begin
                case ($urandom_range(5))
                    0:       level[c] = 0;
                    1:       level[c] = SAMPLE_MAX;
                    2:       level[c] = 136;
                    3:       level[c] = 137;
                    default: level[c] = $urandom_range(SAMPLE_MAX);
                endcase
                spread[c] = ($urandom_range(2) == 0) ? 0 : $urandom_range(24);
                if (first_segment) begin
                    level[c]  = SAMPLE_MAX;
                    spread[c] = 0;
                end
            end
            first_segment = 1'b0;
            for (int k = 0; k < seg_len; k++) begin
                for (int c = 0; c < CHANNELS; c++) begin
                    if (noisy) begin
                        v = $urandom_range(SAMPLE_MAX);
                    end else begin
                        v = level[c] + $urandom_range(2 * spread[c]) - spread[c];
                        if (v < 0) v = 0;
                        if (v > SAMPLE_MAX) v = SAMPLE_MAX;
                    end
                    s[c] = SAMPLE_W'(v);
                end
                offer_set(s, 1'b0, '0);
                random_sets++;
            end
        end
        sample_bus.valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d result transfers from %0d sample sets, with a %0d-cycle stall.",
                 results_seen, sets_sent, STALL_CYCLES);
        $display("Distance map hits per channel: %0d near clamp, %0d far clamp, %0d slope.",
                 near_hits, far_hits, slope_hits);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
